// ===== hw/rtl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// shared codes and controller/datapath signal groups for the frame allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

    // fixed field widths of the request and response channels
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int START_W = 10;
    localparam int STAT_W  = 2;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // response status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADRANGE = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              scan_start;
        logic              scan_step;
        logic              mark_start;
        logic              mark_step;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              respond;
    } cfa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic alloc_len_ok;
        logic free_range_ok;
        logic found;
        logic exhausted;
        logic mark_done;
        logic out_free;
    } cfa_sts_t;

endpackage

// ===== hw/rtl/cfa_if.sv =====
// ----------------------------------------------------------------------------
// cfa_req_if / cfa_rsp_if
// valid/ready channels for allocator requests and responses
// ----------------------------------------------------------------------------
interface cfa_req_if
    import cfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [INDEX_W-1:0] frame_index;
    logic [COUNT_W-1:0] frame_count;

    modport source (output valid, output mode, output frame_index, output frame_count,
                    input ready);
    modport sink   (input valid, input mode, input frame_index, input frame_count,
                    output ready);
endinterface

interface cfa_rsp_if
    import cfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_frame;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] frames_in_use;
    logic [COUNT_W-1:0] frames_free;

    modport source (output valid, output start_frame, output status,
                    output frames_in_use, output frames_free, input ready);
    modport sink   (input valid, input start_frame, input status,
                    input frames_in_use, input frames_free, output ready);
endinterface

// ===== hw/rtl/cfa_ram.sv =====
// ----------------------------------------------------------------------------
// cfa_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/cfa_datapath.sv =====
// ----------------------------------------------------------------------------
// cfa_datapath
// usage bitmap, run scanner, run marker, counters and response register
// ----------------------------------------------------------------------------
module cfa_datapath
    import cfa_pkg::*;
#(
    parameter int TOTAL_FRAMES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfa_cmd_t           cmd,
    output cfa_sts_t           sts,
    input  logic               req_mode,
    input  logic [INDEX_W-1:0] req_frame_index,
    input  logic [COUNT_W-1:0] req_frame_count,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [START_W-1:0] rsp_start_frame,
    output logic [STAT_W-1:0]  rsp_status,
    output logic [COUNT_W-1:0] rsp_frames_in_use,
    output logic [COUNT_W-1:0] rsp_frames_free
);

    localparam int AW  = $clog2(TOTAL_FRAMES);
    localparam int AW1 = $clog2(TOTAL_FRAMES + 1);
    localparam logic [AW1-1:0] TOTAL_A = AW1'(TOTAL_FRAMES);
    localparam logic [31:0]    TOTAL_W = 32'(TOTAL_FRAMES);

    // latched request
    logic               mode_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [AW-1:0]      start_reg;

    // scanner
    logic [AW1-1:0]     rd_addr_reg, rd_addr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [AW-1:0]      chk_pos_reg;
    logic [COUNT_W-1:0] run_reg, run_next;

    // marker
    logic [AW-1:0]      mark_addr_reg, mark_addr_next;
    logic [AW1-1:0]     remain_reg, remain_next;
    logic               mark_val_reg, mark_val_next;

    // counters and response
    logic [AW1-1:0]     used_reg, used_next;
    logic [AW1-1:0]     free_reg, free_next;
    logic               out_valid_reg, out_valid_next;
    logic [START_W-1:0] out_start_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0] out_used_reg;
    logic [COUNT_W-1:0] out_free_reg;

    logic               rd_lt_total;
    logic               ram_re;
    logic               ram_we;
    logic [0:0]         ram_rdata;
    logic [COUNT_W-1:0] run_inc;
    logic               bit_free;
    logic [31:0]        start_wide;
    logic [31:0]        index_wide;
    logic [31:0]        count_wide;
    logic [31:0]        start_out_wide;
    logic [31:0]        used_sum, used_diff, free_sum, free_diff;
    logic               is_alloc;

    cfa_ram #(
        .WIDTH (1),
        .DEPTH (TOTAL_FRAMES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (mark_addr_reg),
        .wdata (mark_val_reg),
        .re    (ram_re),
        .raddr (rd_addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign is_alloc    = (mode_reg == MODE_ALLOC);
    assign index_wide  = 32'(index_reg);
    assign count_wide  = 32'(count_reg);
    assign rd_lt_total = (rd_addr_reg < TOTAL_A);
    assign ram_re      = cmd.scan_step && rd_lt_total;
    assign ram_we      = cmd.mark_step && (remain_reg != '0);
    assign bit_free    = ~ram_rdata[0];
    assign run_inc     = run_reg + COUNT_W'(1);
    // first frame of the run that ends at the frame just read
    assign start_wide  = 32'(chk_pos_reg) + 32'd1 - count_wide;

    assign sts.is_alloc      = is_alloc;
    assign sts.alloc_len_ok  = (count_reg != '0) && (count_wide <= TOTAL_W);
    assign sts.free_range_ok = (index_wide + count_wide) <= TOTAL_W;
    assign sts.found         = chk_valid_reg && bit_free && (run_inc == count_reg);
    assign sts.exhausted     = !chk_valid_reg && !rd_lt_total;
    assign sts.mark_done     = (remain_reg == '0);
    assign sts.out_free      = !out_valid_reg || rsp_ready;

    // scanner and marker next state
    always_comb
    begin
        rd_addr_next   = rd_addr_reg;
        chk_valid_next = 1'b0;
        run_next       = run_reg;
        mark_addr_next = mark_addr_reg;
        remain_next    = remain_reg;
        mark_val_next  = mark_val_reg;

        if (cmd.scan_start)
        begin
            rd_addr_next = '0;
            run_next     = '0;
        end
        else if (cmd.scan_step)
        begin
            chk_valid_next = rd_lt_total;
            if (rd_lt_total)
            begin
                rd_addr_next = rd_addr_reg + AW1'(1);
            end
            if (chk_valid_reg)
            begin
                run_next = bit_free ? run_inc : '0;
            end
        end

        if (cmd.mark_start)
        begin
            remain_next = count_wide[AW1-1:0];
            if (is_alloc)
            begin
                mark_addr_next = start_wide[AW-1:0];
                mark_val_next  = 1'b1;
            end
            else
            begin
                mark_addr_next = index_wide[AW-1:0];
                mark_val_next  = 1'b0;
            end
        end
        else if (ram_we)
        begin
            mark_addr_next = mark_addr_reg + AW'(1);
            remain_next    = remain_reg - AW1'(1);
        end
    end

    // counter update, saturating at both ends
    assign used_sum  = 32'(used_reg) + count_wide;
    assign used_diff = 32'(used_reg) - count_wide;
    assign free_sum  = 32'(free_reg) + count_wide;
    assign free_diff = 32'(free_reg) - count_wide;

    always_comb
    begin
        used_next = used_reg;
        free_next = free_reg;
        if (cmd.respond && (status_reg == ST_OK))
        begin
            if (is_alloc)
            begin
                used_next = (used_sum > TOTAL_W) ? TOTAL_A : used_sum[AW1-1:0];
                free_next = (32'(free_reg) >= count_wide) ? free_diff[AW1-1:0] : '0;
            end
            else
            begin
                used_next = (32'(used_reg) >= count_wide) ? used_diff[AW1-1:0] : '0;
                free_next = (free_sum > TOTAL_W) ? TOTAL_A : free_sum[AW1-1:0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.respond)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign start_out_wide = 32'(start_reg);

    // control state; the marker comes out of reset clearing the whole map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg   <= '0;
            chk_valid_reg <= 1'b0;
            run_reg       <= '0;
            mark_addr_reg <= '0;
            remain_reg    <= TOTAL_A;
            mark_val_reg  <= 1'b0;
            used_reg      <= '0;
            free_reg      <= TOTAL_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_addr_reg   <= rd_addr_next;
            chk_valid_reg <= chk_valid_next;
            run_reg       <= run_next;
            mark_addr_reg <= mark_addr_next;
            remain_reg    <= remain_next;
            mark_val_reg  <= mark_val_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= req_mode;
            index_reg <= req_frame_index;
            count_reg <= req_frame_count;
        end
        if (cmd.scan_step)
        begin
            chk_pos_reg <= rd_addr_reg[AW-1:0];
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.mark_start && is_alloc)
        begin
            start_reg <= start_wide[AW-1:0];
        end
        if (cmd.respond)
        begin
            out_start_reg  <= (is_alloc && (status_reg == ST_OK))
                              ? start_out_wide[START_W-1:0] : '0;
            out_status_reg <= status_reg;
            out_used_reg   <= COUNT_W'(used_next);
            out_free_reg   <= COUNT_W'(free_next);
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_start_frame   = out_start_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_frames_in_use = out_used_reg;
    assign rsp_frames_free   = out_free_reg;

endmodule

// ===== hw/rtl/cfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfa_ctrl
// sequencer for map clearing, request checks, scanning, marking and response
// ----------------------------------------------------------------------------
module cfa_ctrl
    import cfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  cfa_sts_t sts,
    output cfa_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.is_alloc)
                begin
                    if (sts.alloc_len_ok)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOSPACE;
                        state_next      = S_RESP;
                    end
                end
                else if (sts.free_range_ok)
                begin
                    cmd.mark_start  = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_MARK;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_BADRANGE;
                    state_next      = S_RESP;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.found)
                begin
                    cmd.mark_start  = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_MARK;
                end
                else if (sts.exhausted)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOSPACE;
                    state_next      = S_RESP;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/contiguous_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_unit
// first-fit allocator of contiguous frame runs over a one-bit-per-frame map
// ----------------------------------------------------------------------------
// usage
//   req : one request per handshake; mode 0 allocates frame_count frames,
//         mode 1 frees frame_count frames starting at frame_index
//   rsp : one response per request, in order, with the first frame of an
//         allocated run, a status and both frame counters after the request
// sequence
//   allocate : count check, first-fit scan, mark; the scan reads
//              one map bit per cycle from the map ram's single read port
//   free     : range check, then the marker writes one map bit per cycle
//   failed allocate : refused at the check on a zero or oversized count,
//              or after a scan of the whole map when no run fits
//   bad free range : refused at the check
//   one request is in flight at a time; a new request is taken while the
//   previous response is still waiting in the output register
// reset
//   the counters reset at once; the map is then cleared by a pass over
//   every frame during which req.ready stays low
// stall
//   a stalled rsp holds its payload; the next request finishes its work
//   and waits until the output register is free
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_unit
    import cfa_pkg::*;
#(
    parameter int TOTAL_FRAMES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    cfa_req_if.sink        req,
    cfa_rsp_if.source      rsp
);

    // command and status groups between sequencer and datapath
    cfa_cmd_t cmd;
    cfa_sts_t sts;

    // sequencer: owns request acceptance and the order of the work
    cfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: bitmap ram, scanner, marker, counters, response register
    cfa_datapath #(
        .TOTAL_FRAMES (TOTAL_FRAMES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_mode          (req.mode),
        .req_frame_index   (req.frame_index),
        .req_frame_count   (req.frame_count),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_start_frame   (rsp.start_frame),
        .rsp_status        (rsp.status),
        .rsp_frames_in_use (rsp.frames_in_use),
        .rsp_frames_free   (rsp.frames_free)
    );

endmodule

// ===== sim/cfa_alloc_check.sv =====
// ----------------------------------------------------------------------------
// cfa_alloc_check
// watches both allocator channels, predicts each response and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cfa_alloc_check
    import cfa_pkg::*;
#(
    parameter int TOTAL_FRAMES = 1024
) (
    input  logic clk,
    input  logic rst_n,
    cfa_req_if   req,
    cfa_rsp_if   rsp,
    output int   error_count,
    output int   outstanding
);

    typedef struct packed {
        logic [START_W-1:0] start_frame;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] frames_in_use;
        logic [COUNT_W-1:0] frames_free;
    } alloc_reply_t;

    // shadow copy of the frame map and both counters
    logic [TOTAL_FRAMES-1:0] frame_map = '0;
    int unsigned             frames_used = 0;
    int unsigned             frames_avail = TOTAL_FRAMES;
    int                      mismatches = 0;
    alloc_reply_t            awaited_replies[$];

    // first-fit scan from frame 0, then mark or clear the run
    function automatic alloc_reply_t first_fit_outcome(input logic mode,
                                                       input logic [INDEX_W-1:0] at,
                                                       input logic [COUNT_W-1:0] len);
        alloc_reply_t reply;
        int unsigned  span;
        int unsigned  base;
        int unsigned  n;
        bit           hit;
        reply = '0;
        reply.status = ST_OK;
        span = 0;
        base = 0;
        hit = 1'b0;
        n = len;
        if (mode == MODE_ALLOC)
        begin
            if (n != 0 && n <= TOTAL_FRAMES)
            begin
                for (int f = 0; f < TOTAL_FRAMES && !hit; f++)
                begin
                    if (!frame_map[f])
                    begin
                        span++;
                        if (span == n)
                        begin
                            base = f + 1 - n;
                            hit = 1'b1;
                        end
                    end
                    else
                        span = 0;
                end
            end
            if (hit)
            begin
                for (int k = base; k < base + n; k++)
                    frame_map[k] = 1'b1;
                frames_used = (frames_used + n > TOTAL_FRAMES) ? TOTAL_FRAMES
                                                               : frames_used + n;
                frames_avail = (frames_avail >= n) ? frames_avail - n : 0;
                reply.start_frame = START_W'(base);
            end
            else
                reply.status = ST_NOSPACE;
        end
        else if (at + n > TOTAL_FRAMES)
            reply.status = ST_BADRANGE;
        else
        begin
            for (int k = at; k < at + n; k++)
                frame_map[k] = 1'b0;
            frames_used = (frames_used >= n) ? frames_used - n : 0;
            frames_avail = (frames_avail + n > TOTAL_FRAMES) ? TOTAL_FRAMES
                                                             : frames_avail + n;
        end
        reply.frames_in_use = COUNT_W'(frames_used);
        reply.frames_free = COUNT_W'(frames_avail);
        return reply;
    endfunction

    function automatic void compare_field(input string field,
                                          input logic [COUNT_W-1:0] want,
                                          input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        alloc_reply_t want;
        if (!rst_n)
        begin
            frame_map = '0;
            frames_used = 0;
            frames_avail = TOTAL_FRAMES;
            awaited_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response with no request waiting, expected none, got %0d/%0d",
                             $time, rsp.start_frame, rsp.status);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    compare_field("start_frame", COUNT_W'(want.start_frame),
                                  COUNT_W'(rsp.start_frame));
                    compare_field("status", COUNT_W'(want.status), COUNT_W'(rsp.status));
                    compare_field("frames_in_use", want.frames_in_use, rsp.frames_in_use);
                    compare_field("frames_free", want.frames_free, rsp.frames_free);
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                awaited_replies.push_back(first_fit_outcome(req.mode, req.frame_index,
                                                            req.frame_count));
            outstanding <= awaited_replies.size();
        end
        error_count <= mismatches;
    end

endmodule

// ===== sim/tb_contiguous_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_contiguous_frame_allocator_unit
// drives allocate and free requests into the frame allocator with random
// gaps and response back-pressure; a checker beside the unit predicts and
// compares every response, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_contiguous_frame_allocator_unit;
    import cfa_pkg::*;

    localparam int TOTAL_FRAMES = 1024;
    localparam int RANDOM_ITEMS = 580;

    logic clk;
    logic rst_n;
    logic calm;           // no idling on either side while set
    int   fail_count;
    int   in_flight;      // responses still awaited, as the checker sees it

    // what the stimulus remembers of each accepted request
    typedef struct {
        logic               mode;
        logic [COUNT_W-1:0] len;
    } sent_req_t;

    // a run that the unit handed out and that has not been freed yet
    typedef struct {
        logic [START_W-1:0] first;
        logic [COUNT_W-1:0] len;
    } held_run_t;

    sent_req_t issued_q[$];
    held_run_t held_runs[$];

    cfa_req_if req_ch ();
    cfa_rsp_if rsp_ch ();

    contiguous_frame_allocator_unit #(
        .TOTAL_FRAMES (TOTAL_FRAMES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cfa_alloc_check #(
        .TOTAL_FRAMES (TOTAL_FRAMES)
    ) u_alloc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .error_count (fail_count),
        .outstanding (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // response back-pressure: stall with a chance of about 11 in a hundred
    always @(posedge clk)
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 11);

    // learn where each successful allocation landed, so that later frees
    // can hand back real runs
    always @(posedge clk)
    begin : track_replies
        sent_req_t sent;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1 && issued_q.size() != 0)
        begin
            sent = issued_q.pop_front();
            if (sent.mode == MODE_ALLOC && rsp_ch.status == ST_OK)
                held_runs.push_back('{rsp_ch.start_frame, sent.len});
        end
    end

    // one request: random idle cycles first, then hold until accepted
    task automatic issue_request(input logic mode,
                                 input logic [INDEX_W-1:0] at,
                                 input logic [COUNT_W-1:0] len);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.frame_index <= at;
        req_ch.frame_count <= len;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        issued_q.push_back('{mode, len});
    endtask

    // stop sending and let every awaited response come back
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
    endtask

    initial
    begin : stimulus
        held_run_t          victim;
        int                 pick;
        int                 alloc_bias;
        int                 slot;
        logic [COUNT_W-1:0] len;

        rst_n              <= 1'b0;
        calm               <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_ALLOC;
        req_ch.frame_index <= '0;
        req_ch.frame_count <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part, map empty after reset ----
        // zero-length and oversized allocations are refused
        issue_request(MODE_ALLOC, 10'd0, 11'd0);
        issue_request(MODE_ALLOC, 10'd0, 11'd1025);
        issue_request(MODE_ALLOC, 10'd1023, 11'd2047);
        // whole map in one go, then nothing is left
        issue_request(MODE_ALLOC, 10'd0, 11'd1024);
        issue_request(MODE_ALLOC, 10'd0, 11'd1);
        // last frame alone, and runs that reach past the end
        issue_request(MODE_FREE, 10'd1023, 11'd1);
        issue_request(MODE_FREE, 10'd1023, 11'd2);
        issue_request(MODE_FREE, 10'd1023, 11'd2047);
        // free everything, counters saturate
        issue_request(MODE_FREE, 10'd0, 11'd1024);
        // zero-length free, and free of frames not in use
        issue_request(MODE_FREE, 10'd512, 11'd0);
        issue_request(MODE_FREE, 10'd0, 11'd16);
        // fragment the low end and check first fit skips a short hole
        issue_request(MODE_ALLOC, 10'd0, 11'd4);
        issue_request(MODE_ALLOC, 10'd0, 11'd4);
        issue_request(MODE_ALLOC, 10'd0, 11'd4);
        issue_request(MODE_ALLOC, 10'd0, 11'd4);
        issue_request(MODE_FREE, 10'd4, 11'd4);
        issue_request(MODE_ALLOC, 10'd0, 11'd2);
        issue_request(MODE_ALLOC, 10'd0, 11'd3);
        issue_request(MODE_ALLOC, 10'd0, 11'd2);
        // exactly the remaining run up to the last frame
        issue_request(MODE_ALLOC, 10'd0, 11'd1005);
        issue_request(MODE_ALLOC, 10'd0, 11'd1);
        issue_request(MODE_FREE, 10'd0, 11'd1024);
        // index is ignored on allocate
        issue_request(MODE_ALLOC, 10'd1023, 11'd1);
        issue_request(MODE_FREE, 10'd0, 11'd1);

        // hold off until the unit is quiet, then start from a clean list
        drain_replies();
        held_runs.delete();

        // ---- random part ----
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm <= (n >= 180 && n < 300);
            if (n == 400)
                drain_replies();

            // keep the map from filling up: lean towards frees when many
            // runs are held, towards allocations when few are
            if (held_runs.size() > 24)
                alloc_bias = 35;
            else if (held_runs.size() < 4)
                alloc_bias = 75;
            else
                alloc_bias = 55;

            if ($urandom_range(0, 99) < alloc_bias)
            begin
                // mostly short runs, now and then a long or an invalid one
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = COUNT_W'($urandom_range(1, 8));
                else if (pick < 88)
                    len = COUNT_W'($urandom_range(9, 64));
                else if (pick < 97)
                    len = COUNT_W'($urandom_range(65, 400));
                else if (pick < 99)
                    len = COUNT_W'($urandom_range(401, 1024));
                else if ($urandom_range(0, 1) == 0)
                    len = '0;
                else
                    len = COUNT_W'($urandom_range(1025, 2047));
                issue_request(MODE_ALLOC, INDEX_W'($urandom_range(0, 1023)), len);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72 && held_runs.size() != 0)
                begin
                    // hand back a run that was really allocated
                    slot = $urandom_range(0, held_runs.size() - 1);
                    victim = held_runs[slot];
                    held_runs.delete(slot);
                    issue_request(MODE_FREE, victim.first, victim.len);
                end
                else if (pick < 90)
                    issue_request(MODE_FREE, INDEX_W'($urandom_range(0, 1023)),
                                  COUNT_W'($urandom_range(0, 48)));
                else
                    issue_request(MODE_FREE, INDEX_W'($urandom_range(0, 1023)),
                                  COUNT_W'($urandom_range(0, 2047)));
            end
        end

        // wait out everything, then a full allocation's worth of cycles so
        // that a stray response would still be seen
        drain_replies();
        repeat (3 * TOTAL_FRAMES + 16) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
